FILE: rtl/mtd_pkg.sv
// Package for the Morse text decoder: token record type, byte codes and the
// ITU code table. No dependencies.
package mtd_pkg;

    localparam int unsigned MAX_SYMBOLS = 5;
    localparam logic [2:0]  LENGTH_CAP  = 3'd7;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_NONE   = 8'h00;

    // A closed token as it travels from the front end to the decode stage.
    typedef struct packed {
        logic       last;
        logic       slash;
        logic       foreign;
        logic [2:0] length;
        logic [4:0] pattern;
    } token_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Indexed by (1 << length) | pattern, length 1 to 5, dash = 1.
    function automatic logic [7:0] code_lookup(input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd2:  c = "E";
            6'd3:  c = "T";
            6'd4:  c = "I";
            6'd5:  c = "A";
            6'd6:  c = "N";
            6'd7:  c = "M";
            6'd8:  c = "S";
            6'd9:  c = "U";
            6'd10: c = "R";
            6'd11: c = "W";
            6'd12: c = "D";
            6'd13: c = "K";
            6'd14: c = "G";
            6'd15: c = "O";
            6'd16: c = "H";
            6'd17: c = "V";
            6'd18: c = "F";
            6'd20: c = "L";
            6'd22: c = "P";
            6'd23: c = "J";
            6'd24: c = "B";
            6'd25: c = "X";
            6'd26: c = "C";
            6'd27: c = "Y";
            6'd28: c = "Z";
            6'd29: c = "Q";
            6'd32: c = "5";
            6'd33: c = "4";
            6'd35: c = "3";
            6'd39: c = "2";
            6'd47: c = "1";
            6'd48: c = "6";
            6'd56: c = "7";
            6'd60: c = "8";
            6'd62: c = "9";
            6'd63: c = "0";
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/mtd_in_if.sv
// Input channel of the Morse text decoder: one text byte per word.
// No dependencies.
interface mtd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

FILE: rtl/mtd_out_if.sv
// Output channel of the Morse text decoder: one decoded letter per word.
// No dependencies.
interface mtd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] letter;
    logic       letter_valid;
    logic       end_of_text;

    modport source (output valid, output letter, output letter_valid,
                    output end_of_text, input ready);
    modport sink   (input valid, input letter, input letter_valid,
                    input end_of_text, output ready);
endinterface

FILE: rtl/morse_text_decoder.sv
// Channel      Dir  Word
// text_in      in   text_byte[7:0], final_byte
// letter_out   out  letter[7:0], letter_valid, end_of_text
//
// One byte per cycle sustained; a decoded letter passes through a queue slot,
// then the output register, after the byte that closes its token.
// Reset clears the pending token, empties the queue and clears the output valid flag.
// The output and input sides stall independently; input stalls only when
// the token queue is full.
// Depends on mtd_pkg, mtd_in_if, mtd_out_if, mtd_front, mtd_queue, mtd_back.
module morse_text_decoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    mtd_in_if.sink    text_in,
    mtd_out_if.source letter_out
);

    logic            push_valid;
    logic            push_ready;
    mtd_pkg::token_t push_token;
    logic            pop_valid;
    logic            pop_ready;
    mtd_pkg::token_t pop_token;

    mtd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_token (push_token)
    );

    mtd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_token (push_token),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_token  (pop_token)
    );

    mtd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_token  (pop_token),
        .letter_out (letter_out)
    );

endmodule

FILE: rtl/mtd_front.sv
// Front end: takes text bytes, gathers the pending token and pushes a token
// record when it closes. Depends on mtd_pkg, mtd_in_if.
module mtd_front
(
    input  logic            clk,
    input  logic            rst_n,
    mtd_in_if.sink          text_in,
    input  logic            push_ready,
    output logic            push_valid,
    output mtd_pkg::token_t push_token
);

    logic [2:0] length_reg,  length_next;
    logic [4:0] pattern_reg, pattern_next;
    logic       foreign_reg, foreign_next;
    logic       slash_reg,   slash_next;

    logic       take;
    logic       space;
    logic       closes;
    logic [2:0] abs_length;
    logic [4:0] abs_pattern;
    logic       abs_foreign;
    logic       abs_slash;

    // Stall only when the queue is full.
    assign text_in.ready = push_ready;
    assign take          = text_in.valid && push_ready;
    assign space         = mtd_pkg::is_space(text_in.text_byte);

    always_comb
    begin
        abs_length  = length_reg;
        abs_pattern = pattern_reg;
        abs_foreign = foreign_reg;
        abs_slash   = slash_reg;
        if (!space)
        begin
            if (length_reg != mtd_pkg::LENGTH_CAP)
                abs_length = length_reg + 3'd1;
            if ((text_in.text_byte == mtd_pkg::CHAR_DOT) ||
                (text_in.text_byte == mtd_pkg::CHAR_DASH))
                abs_pattern = {pattern_reg[3:0], text_in.text_byte == mtd_pkg::CHAR_DASH};
            else if (text_in.text_byte == mtd_pkg::CHAR_SLASH)
                abs_slash = 1'b1;
            else
                abs_foreign = 1'b1;
        end
    end

    // Whitespace with nothing pending gives no word.
    assign closes = text_in.final_byte || (space && (abs_length != 3'd0));

    assign push_valid         = take && closes;
    assign push_token.last    = text_in.final_byte;
    assign push_token.slash   = abs_slash;
    assign push_token.foreign = abs_foreign;
    assign push_token.length  = abs_length;
    assign push_token.pattern = abs_pattern;

    always_comb
    begin
        length_next  = length_reg;
        pattern_next = pattern_reg;
        foreign_next = foreign_reg;
        slash_next   = slash_reg;
        if (take)
        begin
            if (text_in.final_byte || space)
            begin
                length_next  = 3'd0;
                pattern_next = 5'd0;
                foreign_next = 1'b0;
                slash_next   = 1'b0;
            end
            else
            begin
                length_next  = abs_length;
                pattern_next = abs_pattern;
                foreign_next = abs_foreign;
                slash_next   = abs_slash;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= 3'd0;
            pattern_reg <= 5'd0;
            foreign_reg <= 1'b0;
            slash_reg   <= 1'b0;
        end
        else
        begin
            length_reg  <= length_next;
            pattern_reg <= pattern_next;
            foreign_reg <= foreign_next;
            slash_reg   <= slash_next;
        end
    end

endmodule

FILE: rtl/mtd_queue.sv
// Short queue of closed tokens between front end and decode stage.
// Depends on mtd_pkg.
module mtd_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  mtd_pkg::token_t push_token,
    output logic            push_ready,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mtd_pkg::token_t pop_token
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mtd_pkg::token_t          store_reg [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         count_reg,  count_next;
    logic                     do_push;
    logic                     do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_token  = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_token;
    end

endmodule

FILE: rtl/mtd_back.sv
// Decode stage: looks a closed token up in the code table and holds the
// result in the output register. Depends on mtd_pkg, mtd_out_if.
module mtd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  mtd_pkg::token_t pop_token,
    mtd_out_if.source       letter_out
);

    logic       valid_reg,  valid_next;
    logic [7:0] letter_reg, letter_next;
    logic       lvalid_reg, lvalid_next;
    logic       eot_reg,    eot_next;

    logic [7:0] decoded;
    logic [5:0] idx;

    assign idx = (6'd1 << pop_token.length) | {1'b0, pop_token.pattern};

    always_comb
    begin
        if (pop_token.foreign)
            decoded = mtd_pkg::CHAR_NONE;
        else if (pop_token.slash)
            decoded = (pop_token.length == 3'd1) ? mtd_pkg::CHAR_SPACE : mtd_pkg::CHAR_NONE;
        else if ((pop_token.length == 3'd0) ||
                 (pop_token.length > 3'(mtd_pkg::MAX_SYMBOLS)))
            decoded = mtd_pkg::CHAR_NONE;
        else
            decoded = mtd_pkg::code_lookup(idx);
    end

    assign pop_ready = !valid_reg || letter_out.ready;

    always_comb
    begin
        valid_next  = valid_reg;
        letter_next = letter_reg;
        lvalid_next = lvalid_reg;
        eot_next    = eot_reg;
        if (pop_ready)
        begin
            valid_next  = pop_valid;
            letter_next = decoded;
            lvalid_next = pop_token.length != 3'd0;
            eot_next    = pop_token.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        lvalid_reg <= lvalid_next;
        eot_reg    <= eot_next;
    end

    assign letter_out.valid        = valid_reg;
    assign letter_out.letter       = letter_reg;
    assign letter_out.letter_valid = lvalid_reg;
    assign letter_out.end_of_text  = eot_reg;

endmodule

FILE: dv/mtd_checker.sv
// Scoreboard for the Morse text decoder: follows the token state from the
// input words, predicts each letter word and compares it with the output.
// Depends on mtd_pkg, mtd_in_if, mtd_out_if.
`timescale 1ns / 1ps

module mtd_checker
(
    input  logic clk,
    input  logic rst_n,
    mtd_in_if    text_in,
    mtd_out_if   letter_out,
    output int   fail_count,
    output int   letters_owed
);

    typedef struct packed {
        logic [7:0] letter;
        logic       letter_valid;
        logic       end_of_text;
    } letter_word_t;

    // Binary tree walk of the ITU code: entry n-2 holds the character for
    // index (1 << length) | pattern, dash = 1, first symbol in the MSB.
    localparam string MORSE_TREE =
        "ETIANMSURWDKGOHVF*L*PJBXCYZQ**54*3***2*******16*******7***8*90";
    localparam byte NO_ENTRY = "*";

    logic [2:0] tok_len;
    logic [4:0] tok_dashes;
    logic       tok_foreign;
    logic       tok_slash;

    letter_word_t letters_due[$];
    int           n_fail;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == mtd_pkg::CHAR_SPACE) ||
               ((c >= mtd_pkg::CHAR_TAB) && (c <= mtd_pkg::CHAR_CR));
    endfunction

    function automatic logic [7:0] token_char();
        logic [5:0] idx;
        byte        ch;
        if (tok_foreign)
            return mtd_pkg::CHAR_NONE;
        if (tok_slash)
            return (tok_len == 3'd1) ? mtd_pkg::CHAR_SPACE : mtd_pkg::CHAR_NONE;
        if ((tok_len == 3'd0) || (tok_len > mtd_pkg::MAX_SYMBOLS))
            return mtd_pkg::CHAR_NONE;
        idx = (6'd1 << tok_len) | {1'b0, tok_dashes};
        ch  = MORSE_TREE[int'(idx) - 2];
        return (ch == NO_ENTRY) ? mtd_pkg::CHAR_NONE : ch;
    endfunction

    // Advances the token state by one text byte; returns 1 when a letter word
    // is due, with its contents in res.
    function automatic logic decode_byte(input logic [7:0] c, input logic last,
                                         output letter_word_t res);
        logic blank;
        logic open;
        blank = is_blank(c);
        if (!blank)
        begin
            if (tok_len < mtd_pkg::LENGTH_CAP)
                tok_len = tok_len + 3'd1;
            if ((c == mtd_pkg::CHAR_DOT) || (c == mtd_pkg::CHAR_DASH))
                tok_dashes = {tok_dashes[3:0], c == mtd_pkg::CHAR_DASH};
            else if (c == mtd_pkg::CHAR_SLASH)
                tok_slash = 1'b1;
            else
                tok_foreign = 1'b1;
        end
        res  = '0;
        open = (tok_len != 3'd0);
        if ((!last && !blank) || (!open && !last))
            return 1'b0;
        res.letter       = open ? token_char() : mtd_pkg::CHAR_NONE;
        res.letter_valid = open;
        res.end_of_text  = last;
        tok_len     = '0;
        tok_dashes  = '0;
        tok_foreign = 1'b0;
        tok_slash   = 1'b0;
        return 1'b1;
    endfunction

    task automatic log_fail(input string what);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t mtd_checker: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        letter_word_t got;
        letter_word_t want;
        if (!rst_n)
        begin
            tok_len     = '0;
            tok_dashes  = '0;
            tok_foreign = 1'b0;
            tok_slash   = 1'b0;
            letters_due.delete();
            n_fail = 0;
            fail_count   <= 0;
            letters_owed <= 0;
        end
        else
        begin
            // output side first: a letter can never leave on the edge its
            // closing byte goes in
            if (letter_out.valid && letter_out.ready)
            begin
                got = '{letter_out.letter, letter_out.letter_valid,
                        letter_out.end_of_text};
                if (letters_due.size() == 0)
                    log_fail($sformatf("unexpected word letter=%02h valid=%b eot=%b",
                                       got.letter, got.letter_valid, got.end_of_text));
                else
                begin
                    want = letters_due.pop_front();
                    if (got !== want)
                        log_fail($sformatf({"mismatch letter exp %02h got %02h, ",
                                            "valid exp %b got %b, eot exp %b got %b"},
                                           want.letter, got.letter,
                                           want.letter_valid, got.letter_valid,
                                           want.end_of_text, got.end_of_text));
                end
            end
            if (text_in.valid && text_in.ready)
            begin
                if (decode_byte(text_in.text_byte, text_in.final_byte, want))
                    letters_due.push_back(want);
            end
            fail_count   <= n_fail;
            letters_owed <= letters_due.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for morse_text_decoder: clock, reset, text stimulus and
// output back-pressure; checking is done in mtd_checker.
// Depends on mtd_pkg, mtd_in_if, mtd_out_if, mtd_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_WORDS = 1650;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;
    int hold_left = 0;
    int n_sent    = 0;
    int fail_count;
    int letters_owed;

    int phase_idle[4]  = '{0, 78, 0, 13};
    int phase_stall[4] = '{0, 0, 78, 13};

    mtd_in_if  in_ch();
    mtd_out_if out_ch();

    morse_text_decoder u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (in_ch),
        .letter_out (out_ch)
    );

    mtd_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_in      (in_ch),
        .letter_out   (out_ch),
        .fail_count   (fail_count),
        .letters_owed (letters_owed)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_req != 0)
            begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    function automatic logic [7:0] random_blank();
        int pick;
        pick = $urandom_range(5, 0);
        return (pick == 5) ? mtd_pkg::CHAR_SPACE : mtd_pkg::CHAR_TAB + 8'(pick);
    endfunction

    function automatic logic [7:0] random_symbol();
        return $urandom_range(1, 0) ? mtd_pkg::CHAR_DASH : mtd_pkg::CHAR_DOT;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        while ((idle_pct != 0) && ($urandom_range(99, 0) < idle_pct))
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.text_byte  <= b;
        in_ch.final_byte <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic send_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], ends && (i == s.len() - 1));
    endtask

    // stops offering words and waits until every letter has come out
    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (letters_owed != 0);
    endtask

    // one token; its last byte carries the final flag when ends is set
    task automatic send_token(input logic ends);
        int kind;
        int len;
        kind = $urandom_range(99, 0);
        if (kind < 94)
        begin
            if (kind < 70)
                len = $urandom_range(5, 1);
            else if (kind < 78)
                len = 1;
            else if (kind < 86)
                len = $urandom_range(12, 6);
            else
                len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
            begin
                if (kind >= 70 && kind < 78)
                    send_word(mtd_pkg::CHAR_SLASH, ends);
                else if (kind >= 86)
                begin
                    case ($urandom_range(3, 0))
                        0: send_word(mtd_pkg::CHAR_SLASH, ends && (i == len - 1));
                        1: send_word(8'($urandom_range(255, 0)), ends && (i == len - 1));
                        default: send_word(random_symbol(), ends && (i == len - 1));
                    endcase
                end
                else
                    send_word(random_symbol(), ends && (i == len - 1));
            end
        end
        else
            send_word(8'($urandom_range(255, 0)), ends || ($urandom_range(7, 0) == 0));
    endtask

    task automatic send_random(input int count);
        int stop_at;
        int pick;
        stop_at = n_sent + count;
        while (n_sent < stop_at)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 6)
                send_token(1'b1);
            else
            begin
                send_token(1'b0);
                repeat ($urandom_range(3, 0) == 0 ? 2 : 1)
                    send_word(random_blank(), 1'b0);
                if (pick < 12)
                    send_word(random_blank(), 1'b1);
            end
        end
    endtask

    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.text_byte  <= mtd_pkg::CHAR_NONE;
        in_ch.final_byte <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text
        send_word(mtd_pkg::CHAR_SPACE, 1'b0);        // blank with nothing pending
        send_text(".-", 1'b0);
        send_word(mtd_pkg::CHAR_TAB, 1'b0);
        send_text("/", 1'b0);
        send_word(mtd_pkg::CHAR_CR, 1'b0);
        send_text("..--", 1'b0);                     // legal length, no letter
        send_word(8'h0A, 1'b0);
        send_text("/.", 1'b0);                       // slash mixed with a dot
        send_word(8'h0B, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(mtd_pkg::CHAR_NONE, 1'b1);         // foreign token closed by final
        send_word(mtd_pkg::CHAR_SPACE, 1'b1);        // final with nothing pending
        send_text("------", 1'b1);                   // too long, final not blank
        drain();

        // long output hold-off while the sender keeps going
        hold_req = 1;
        repeat (30)
        begin
            send_word(random_symbol(), 1'b0);
            send_word(mtd_pkg::CHAR_SPACE, 1'b0);
        end
        drain();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            send_random(RANDOM_WORDS / 4);
        end
        idle_pct = 0;
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if ((fail_count == 0) && (letters_owed == 0))
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mtd_pkg.sv
rtl/mtd_in_if.sv
rtl/mtd_out_if.sv
rtl/mtd_front.sv
rtl/mtd_queue.sv
rtl/mtd_back.sv
rtl/morse_text_decoder.sv
dv/mtd_checker.sv
dv/tb_top.sv
